[rtl/core/sha1_hash_engine_top_assert.svh]
// Assertion macros for the SHA-1 engine.
`ifndef SHA1_HASH_ENGINE_TOP_ASSERT_SVH
`define SHA1_HASH_ENGINE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SHA1_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 assertion failed");

`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 assertion failed");

`else

`define SHA1_ASSERT_NOW(label, clk, rst, ante, cons)

`define SHA1_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/sha1_pkg.sv]
package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam int unsigned HASH_WORDS = 5;

  localparam logic [31:0] IV [HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [6:0] SCHED_LOAD = 7'd16;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    priority if (t < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      r = b ^ c ^ d;
    end else if (t < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] r;
    priority if (t < 7'd20) begin
      r = K0;
    end else if (t < 7'd40) begin
      r = K1;
    end else if (t < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

endpackage

[rtl/core/sha1_if.sv]
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;

  modport source(output valid, data_byte, byte_present, message_end, input ready);
  modport sink(input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, digest_word, word_index, last_word, input ready);
  modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

[rtl/core/sha1_hash_engine_top.sv]
// Channel   Dir  Payload                                   Transfer
// msg       in   data_byte[8], byte_present, message_end   valid && ready
// digest    out  digest_word[32], word_index[3], last_word valid && ready
//
// A message byte is written into the block memory as it is taken; the byte that
// fills a block adds a compression (load, 80 rounds on the single round unit, fold
// into the chaining value). A closing transfer adds byte-wide padding writes into
// the block memory, one or two compressions, and then five digest transfers.
// Reset is synchronous and takes effect at once; the block memory needs no clearing.
// Input is held off while a block is compressed, padded or the digest is out.
`include "sha1_hash_engine_top_assert.svh"

module sha1_hash_engine_top (
  input logic         clk,
  input logic         rst,
  sha1_in_if.sink     msg,
  sha1_out_if.source  digest
);

  sha1_pkg::state_t state, state_next;

  logic [5:0]  pos;
  logic [63:0] bit_count;
  logic        end_pending;
  logic        pad_active;
  logic        pad_first;
  logic        final_blk;
  logic [6:0]  t;
  logic [2:0]  idx;
  logic [31:0] h [sha1_pkg::HASH_WORDS];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w_sr [16];

  logic [31:0] blk_mem [16];
  logic [31:0] rd_data;

  logic        msg_xfer;
  logic        out_xfer;
  logic        mem_we;
  logic [7:0]  mem_wdata;
  logic [3:0]  mem_raddr;
  logic [31:0] w_cur;
  logic [31:0] round_sum;

  assign msg_xfer = msg.valid && msg.ready;
  assign out_xfer = digest.valid && digest.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      sha1_pkg::ST_IDLE: begin
        if (msg_xfer) begin
          if (msg.byte_present && pos == sha1_pkg::LAST_BYTE) begin
            state_next = sha1_pkg::ST_LOAD;
          end else if (msg.message_end) begin
            state_next = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        if (pos == sha1_pkg::LAST_BYTE) begin
          state_next = sha1_pkg::ST_LOAD;
        end
      end
      sha1_pkg::ST_LOAD: state_next = sha1_pkg::ST_ROUND;
      sha1_pkg::ST_ROUND: begin
        if (t == sha1_pkg::LAST_ROUND) begin
          state_next = sha1_pkg::ST_FOLD;
        end
      end
      sha1_pkg::ST_FOLD: begin
        priority if (pad_active && final_blk) begin
          state_next = sha1_pkg::ST_OUT;
        end else if (pad_active || end_pending) begin
          state_next = sha1_pkg::ST_PAD;
        end else begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      sha1_pkg::ST_OUT: begin
        if (out_xfer && idx == sha1_pkg::LAST_WORD) begin
          state_next = sha1_pkg::ST_IDLE;
        end
      end
      default: state_next = sha1_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    msg.ready          = (state == sha1_pkg::ST_IDLE);
    digest.valid       = (state == sha1_pkg::ST_OUT);
    digest.digest_word = h[idx];
    digest.word_index  = idx;
    digest.last_word   = (idx == sha1_pkg::LAST_WORD);
    mem_we             = 1'b0;
    mem_wdata          = msg.data_byte;
    mem_raddr          = 4'd0;
    unique case (state)
      sha1_pkg::ST_IDLE: mem_we = msg_xfer && msg.byte_present;
      sha1_pkg::ST_PAD: begin
        mem_we = 1'b1;
        priority if (pad_first) begin
          mem_wdata = sha1_pkg::PAD_BYTE;
        end else if (final_blk && pos >= sha1_pkg::LEN_OFFSET) begin
          mem_wdata = bit_count[{~pos[2:0], 3'b000} +: 8];
        end else begin
          mem_wdata = 8'h00;
        end
      end
      sha1_pkg::ST_ROUND: mem_raddr = t[3:0] + 4'd1;
      default: mem_raddr = 4'd0;
    endcase
  end

  // Bytes are packed big-endian into 32-bit words of the block memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      blk_mem[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= mem_wdata;
    end
    rd_data <= blk_mem[mem_raddr];
  end

  always_comb begin
    if (t < sha1_pkg::SCHED_LOAD) begin
      w_cur = rd_data;
    end else begin
      w_cur = w_sr[13] ^ w_sr[8] ^ w_sr[2] ^ w_sr[0];
      w_cur = {w_cur[30:0], w_cur[31]};
    end
    round_sum = {a[26:0], a[31:27]} + sha1_pkg::round_f(t, b, c, d) + e
              + sha1_pkg::round_k(t) + w_cur;
  end

  always_ff @(posedge clk) begin
    if (state == sha1_pkg::ST_LOAD) begin
      a <= h[0];
      b <= h[1];
      c <= h[2];
      d <= h[3];
      e <= h[4];
    end else if (state == sha1_pkg::ST_ROUND) begin
      a <= round_sum;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
      for (int i = 0; i < 15; i++) begin
        w_sr[i] <= w_sr[i+1];
      end
      w_sr[15] <= w_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha1_pkg::ST_IDLE;
      pos         <= 6'd0;
      bit_count   <= 64'd0;
      end_pending <= 1'b0;
      pad_active  <= 1'b0;
      pad_first   <= 1'b0;
      final_blk   <= 1'b0;
      t           <= 7'd0;
      idx         <= 3'd0;
      h           <= sha1_pkg::IV;
    end else begin
      state <= state_next;
      unique case (state)
        sha1_pkg::ST_IDLE: begin
          if (msg_xfer) begin
            end_pending <= msg.message_end;
            pad_active  <= 1'b0;
            pad_first   <= 1'b1;
            if (msg.byte_present) begin
              pos       <= pos + 6'd1;
              bit_count <= bit_count + sha1_pkg::BITS_PER_BYTE;
            end
          end
        end
        sha1_pkg::ST_PAD: begin
          pos        <= pos + 6'd1;
          pad_active <= 1'b1;
          if (pad_first) begin
            pad_first <= 1'b0;
            final_blk <= (pos < sha1_pkg::LEN_OFFSET);
          end
        end
        sha1_pkg::ST_LOAD: t <= 7'd0;
        sha1_pkg::ST_ROUND: t <= t + 7'd1;
        sha1_pkg::ST_FOLD: begin
          h[0] <= h[0] + a;
          h[1] <= h[1] + b;
          h[2] <= h[2] + c;
          h[3] <= h[3] + d;
          h[4] <= h[4] + e;
          if (pad_active) begin
            final_blk <= 1'b1;
          end
        end
        sha1_pkg::ST_OUT: begin
          if (out_xfer) begin
            if (idx == sha1_pkg::LAST_WORD) begin
              idx         <= 3'd0;
              h           <= sha1_pkg::IV;
              pos         <= 6'd0;
              bit_count   <= 64'd0;
              end_pending <= 1'b0;
              pad_active  <= 1'b0;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: t <= 7'd0;
      endcase
    end
  end

  `SHA1_ASSERT_NOW(a_no_input_while_output, clk, rst, digest.valid, !msg.ready)
  `SHA1_ASSERT_NEXT(a_rounds_end_in_fold, clk, rst,
                    state == sha1_pkg::ST_ROUND && t == sha1_pkg::LAST_ROUND,
                    state == sha1_pkg::ST_FOLD)
  `SHA1_ASSERT_NEXT(a_reinit_after_digest, clk, rst,
                    out_xfer && digest.last_word,
                    state == sha1_pkg::ST_IDLE && pos == 6'd0 && bit_count == 64'd0)

endmodule
